// ===== hw/rtl/skq_pkg.sv =====
package skq_pkg;

  // Character width carried through the queue.
  localparam int unsigned CHAR_W = 8;

  // Stream kinds on the input tuser bit.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character produced by the decoder for the ring.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } skq_enq_t;

  // Read response leaving the ring, registered in the cycle after the read was issued.
  typedef struct packed {
    logic              valid;
    logic              empty;
    logic [CHAR_W-1:0] data;
  } skq_rsp_t;

endpackage

// ===== hw/rtl/skq_decode.sv =====
module skq_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      scan_go,
  input  logic [7:0]                scan_code,
  output skq_pkg::skq_enq_t         enq
);
  import skq_pkg::*;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] SC_CTRL     = 7'h1D;
  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CAPS     = 7'h3A;
  localparam logic [6:0] SC_UP       = 7'h48;
  localparam logic [6:0] SC_DOWN     = 7'h50;
  localparam logic [6:0] SC_LEFT     = 7'h4B;
  localparam logic [6:0] SC_RIGHT    = 7'h4D;
  localparam logic [7:0] CODE_UP     = 8'h81;
  localparam logic [7:0] CODE_DOWN   = 8'h82;
  localparam logic [7:0] CODE_LEFT   = 8'h83;
  localparam logic [7:0] CODE_RIGHT  = 8'h84;

  // Unshifted key table.
  function automatic logic [7:0] rom_plain(input logic [6:0] code);
    logic [7:0] r;
    case (code)
      7'd1:  r = 8'h1B;  7'd2:  r = 8'h31;  7'd3:  r = 8'h32;  7'd4:  r = 8'h33;
      7'd5:  r = 8'h34;  7'd6:  r = 8'h35;  7'd7:  r = 8'h36;  7'd8:  r = 8'h37;
      7'd9:  r = 8'h38;  7'd10: r = 8'h39;  7'd11: r = 8'h30;  7'd12: r = 8'h2D;
      7'd13: r = 8'h3D;  7'd14: r = 8'h08;  7'd15: r = 8'h09;  7'd16: r = 8'h71;
      7'd17: r = 8'h77;  7'd18: r = 8'h65;  7'd19: r = 8'h72;  7'd20: r = 8'h74;
      7'd21: r = 8'h79;  7'd22: r = 8'h75;  7'd23: r = 8'h69;  7'd24: r = 8'h6F;
      7'd25: r = 8'h70;  7'd26: r = 8'h5B;  7'd27: r = 8'h5D;  7'd28: r = 8'h0A;
      7'd30: r = 8'h61;  7'd31: r = 8'h73;  7'd32: r = 8'h64;  7'd33: r = 8'h66;
      7'd34: r = 8'h67;  7'd35: r = 8'h68;  7'd36: r = 8'h6A;  7'd37: r = 8'h6B;
      7'd38: r = 8'h6C;  7'd39: r = 8'h3B;  7'd40: r = 8'h27;  7'd41: r = 8'h60;
      7'd43: r = 8'h5C;  7'd44: r = 8'h7A;  7'd45: r = 8'h78;  7'd46: r = 8'h63;
      7'd47: r = 8'h76;  7'd48: r = 8'h62;  7'd49: r = 8'h6E;  7'd50: r = 8'h6D;
      7'd51: r = 8'h2C;  7'd52: r = 8'h2E;  7'd53: r = 8'h2F;  7'd55: r = 8'h2A;
      7'd57: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Shifted key table.
  function automatic logic [7:0] rom_shifted(input logic [6:0] code);
    logic [7:0] r;
    case (code)
      7'd1:  r = 8'h1B;  7'd2:  r = 8'h21;  7'd3:  r = 8'h40;  7'd4:  r = 8'h23;
      7'd5:  r = 8'h24;  7'd6:  r = 8'h25;  7'd7:  r = 8'h5E;  7'd8:  r = 8'h26;
      7'd9:  r = 8'h2A;  7'd10: r = 8'h28;  7'd11: r = 8'h29;  7'd12: r = 8'h5F;
      7'd13: r = 8'h2B;  7'd14: r = 8'h08;  7'd15: r = 8'h09;  7'd16: r = 8'h51;
      7'd17: r = 8'h57;  7'd18: r = 8'h45;  7'd19: r = 8'h52;  7'd20: r = 8'h54;
      7'd21: r = 8'h59;  7'd22: r = 8'h55;  7'd23: r = 8'h49;  7'd24: r = 8'h4F;
      7'd25: r = 8'h50;  7'd26: r = 8'h7B;  7'd27: r = 8'h7D;  7'd28: r = 8'h0A;
      7'd30: r = 8'h41;  7'd31: r = 8'h53;  7'd32: r = 8'h44;  7'd33: r = 8'h46;
      7'd34: r = 8'h47;  7'd35: r = 8'h48;  7'd36: r = 8'h4A;  7'd37: r = 8'h4B;
      7'd38: r = 8'h4C;  7'd39: r = 8'h3A;  7'd40: r = 8'h22;  7'd41: r = 8'h7E;
      7'd43: r = 8'h7C;  7'd44: r = 8'h5A;  7'd45: r = 8'h58;  7'd46: r = 8'h43;
      7'd47: r = 8'h56;  7'd48: r = 8'h42;  7'd49: r = 8'h4E;  7'd50: r = 8'h4D;
      7'd51: r = 8'h3C;  7'd52: r = 8'h3E;  7'd53: r = 8'h3F;  7'd55: r = 8'h2A;
      7'd57: r = 8'h20;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic shift_held, shift_held_next;
  logic caps_on, caps_on_next;
  logic ctrl_held, ctrl_held_next;
  logic prefix_seen, prefix_seen_next;

  logic       rel;
  logic [6:0] code;
  logic [7:0] rom_ch;
  logic [7:0] lc;
  logic       hit;
  logic [7:0] ch;

  assign rel  = scan_code[7];
  assign code = scan_code[6:0];

  // Table lookup, folded to lower case for the letter rules.
  always_comb begin
    rom_ch = shift_held ? rom_shifted(code) : rom_plain(code);
    lc = (rom_ch >= 8'h41 && rom_ch <= 8'h5A) ? rom_ch + 8'h20 : rom_ch;
  end

  // Modifier update and character selection for one scancode.
  always_comb begin
    shift_held_next  = shift_held;
    caps_on_next     = caps_on;
    ctrl_held_next   = ctrl_held;
    prefix_seen_next = prefix_seen;
    hit = 1'b0;
    ch  = 8'h00;
    if (scan_code == PREFIX_BYTE) begin
      prefix_seen_next = 1'b1;
    end else if (code == SC_CTRL) begin
      ctrl_held_next   = !rel;
      prefix_seen_next = 1'b0;
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_held_next  = !rel;
      prefix_seen_next = 1'b0;
    end else if (code == SC_CAPS && !rel) begin
      caps_on_next     = !caps_on;
      prefix_seen_next = 1'b0;
    end else if (rel) begin
      prefix_seen_next = 1'b0;
    end else if (prefix_seen) begin
      // Extended press: only the arrow keys produce a code.
      prefix_seen_next = 1'b0;
      hit = 1'b1;
      case (code)
        SC_UP:    ch = CODE_UP;
        SC_DOWN:  ch = CODE_DOWN;
        SC_LEFT:  ch = CODE_LEFT;
        SC_RIGHT: ch = CODE_RIGHT;
        default:  hit = 1'b0;
      endcase
    end else if (rom_ch != 8'h00) begin
      hit = 1'b1;
      if (lc >= 8'h61 && lc <= 8'h7A) begin
        if (ctrl_held) begin
          ch = lc - 8'h60;
        end else if (shift_held != caps_on) begin
          ch = lc - 8'h20;
        end else begin
          ch = lc;
        end
      end else begin
        ch = lc;
      end
    end
  end

  assign enq.valid = scan_go && hit;
  assign enq.ch    = ch;

  // Modifier registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      caps_on     <= 1'b0;
      ctrl_held   <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (scan_go) begin
      shift_held  <= shift_held_next;
      caps_on     <= caps_on_next;
      ctrl_held   <= ctrl_held_next;
      prefix_seen <= prefix_seen_next;
    end
  end

endmodule

// ===== hw/rtl/skq_ring.sv =====
module skq_ring #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  skq_pkg::skq_enq_t enq,
  input  logic              rd_go,
  output skq_pkg::skq_rsp_t rsp
);
  import skq_pkg::*;

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [CHAR_W-1:0] mem [RING_DEPTH];
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [PTR_W-1:0]  write_ptr_next;
  logic [PTR_W-1:0]  read_ptr_next;
  logic              empty;
  logic              full;
  logic              rsp_valid;
  logic              rsp_empty;
  logic [CHAR_W-1:0] mem_q;

  // Pointer arithmetic modulo the ring depth.
  assign write_ptr_next = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
  assign read_ptr_next  = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;
  assign empty = (write_ptr == read_ptr);
  assign full  = (write_ptr_next == read_ptr);

  // Character store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (enq.valid && !full) begin
      mem[write_ptr] <= enq.ch;
    end
    if (rd_go) begin
      mem_q <= mem[read_ptr];
    end
  end

  // Pointers and the response stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      rsp_valid <= 1'b0;
      rsp_empty <= 1'b0;
    end else begin
      if (enq.valid && !full) begin
        write_ptr <= write_ptr_next;
      end
      if (rd_go && !empty) begin
        read_ptr <= read_ptr_next;
      end
      rsp_valid <= rd_go;
      rsp_empty <= empty;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.empty = rsp_empty;
  assign rsp.data  = rsp_empty ? '0 : mem_q;

  // A scancode and a read never share a cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(enq.valid && rd_go))
    else $error("ring write and read issued together");

  // Every read produces a response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    rd_go |=> rsp_valid)
    else $error("read response missing");

  // A non-empty response moved the read pointer by one.
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    (rd_go && !empty) |=> (read_ptr == $past(read_ptr_next)) && !rsp_empty)
    else $error("read pointer did not advance");

endmodule

// ===== hw/rtl/skq_outq.sv =====
module skq_outq (
  input  logic              clk,
  input  logic              rst,
  input  skq_pkg::skq_rsp_t rsp,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_empty
);
  import skq_pkg::*;

  localparam int unsigned DEPTH = 3;
  localparam logic [1:0]  IDX_LAST = 2'(DEPTH - 1);

  logic [CHAR_W:0] slot [DEPTH];
  logic [1:0]      wr_idx;
  logic [1:0]      rd_idx;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push = rsp.valid;
  assign pop  = out_valid && out_ready;

  // Room for one more read counts the response already in flight.
  assign room = ({1'b0, count} + {2'b00, rsp.valid}) < 3'(DEPTH);

  // Result slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_idx] <= {rsp.empty, rsp.data};
    end
  end

  // Slot indexes and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid = (count != '0);
  assign out_char  = slot[rd_idx][CHAR_W-1:0];
  assign out_empty = slot[rd_idx][CHAR_W];

  // A response never arrives when every slot is taken.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (count < 2'(DEPTH)))
    else $error("result queue overflow");

  // The fill count never exceeds the slot count.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("result queue count out of range");

  // An idle cycle on both sides leaves the count alone.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(count))
    else $error("result queue count moved without a transaction");

endmodule

// ===== hw/rtl/scancode_to_ascii_key_queue_core.sv =====
// Keyboard scancode decoder with a character queue.
// The slave stream carries one item per transaction: tuser selects the kind
// (0 = scancode byte in tdata, 1 = read the oldest queued character).
// Scancodes update the Shift, Ctrl, Caps Lock and extended-prefix state and
// may append one character to a ring of RING_DEPTH entries (at most
// RING_DEPTH - 1 held); a character is dropped when the ring is full.
// Each read yields exactly one master transaction: tdata holds the
// character, tuser is set when the ring was empty (tdata is then 0).
// Scancodes produce no master transaction.
// Throughput is one item per cycle while s_axis_tready is high; the ring
// memory takes one write or one read per cycle and each item uses at most
// one of them. A read result reaches the master side through the registered
// memory read and then a slot of the three-entry result queue.
// When the receiver stalls, results collect in that queue; s_axis_tready
// drops once the queue plus the response in flight fill it, and the
// queue drains in order as the receiver takes transactions.
// Reset clears the modifier state, both ring pointers and the result queue;
// the ring memory itself is not cleared.
module scancode_to_ascii_key_queue_core #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
  input  logic       s_axis_tuser,   // [0] op
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic       m_axis_tuser    // [0] queue_empty
);
  import skq_pkg::*;

  skq_enq_t enq;
  skq_rsp_t rsp;
  logic     room;
  logic     accept;
  logic     scan_go;
  logic     rd_go;

  assign s_axis_tready = room;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign scan_go = accept && (s_axis_tuser == OP_SCAN);
  assign rd_go   = accept && (s_axis_tuser == OP_READ);

  skq_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .scan_go   (scan_go),
    .scan_code (s_axis_tdata),
    .enq       (enq)
  );

  skq_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .enq   (enq),
    .rd_go (rd_go),
    .rsp   (rsp)
  );

  skq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .rsp       (rsp),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_empty (m_axis_tuser)
  );

endmodule
